[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: check failed");

// Condition that must never hold at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

[sv/sevt_pkg.sv]
// ----------------------------------------------------------------------------
// sevt_pkg
// Codes, field widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package sevt_pkg;

	localparam int IDX_W = 6;
	localparam int KEY_W = 34;
	localparam int PAY_W = 32;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_FULL = 2'd1;
	localparam logic [1:0] STS_OOR  = 2'd2;

	localparam logic [1:0] KIND_SINGLE    = 2'd0;
	localparam logic [1:0] KIND_REPEATING = 2'd1;
	localparam logic [1:0] KIND_BIRTHDAY  = 2'd2;

	typedef enum logic [1:0] {
		RA_PTR,
		RA_PREV,
		RA_NEXT
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    wr_new;
		logic    ptr_inc;
		logic    ptr_dec;
		logic    commit;
	} sevt_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       full;
		logic       oor;
		logic       ptr_zero;
		logic       del_end;
		logic       key_less;
	} sevt_sts_t;

endpackage

`default_nettype wire

[sv/sevt_dpath.sv]
// ----------------------------------------------------------------------------
// sevt_dpath
// Entry memories, operand and pointer registers, count and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sevt_dpath #(
	parameter int ENTRIES = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sevt_pkg::sevt_cmd_t   cmd,
	output sevt_pkg::sevt_sts_t        sts,
	input  wire logic [1:0]            action,
	input  wire logic [5:0]            index,
	input  wire logic [13:0]           year,
	input  wire logic [3:0]            month,
	input  wire logic [4:0]            day,
	input  wire logic [4:0]            hour,
	input  wire logic [5:0]            minute,
	input  wire logic                  birthday,
	input  wire logic [14:0]           repeat_days,
	input  wire logic [15:0]           tag,
	output logic [1:0]                 status,
	output logic [5:0]                 position,
	output logic                       placed_last,
	output logic [13:0]                out_year,
	output logic [3:0]                 out_month,
	output logic [4:0]                 out_day,
	output logic [4:0]                 out_hour,
	output logic [5:0]                 out_minute,
	output logic [1:0]                 kind,
	output logic [14:0]                out_repeat_days,
	output logic [15:0]                out_tag,
	output logic [5:0]                 entry_count
);
	import sevt_pkg::*;

	localparam int AW   = $clog2(ENTRIES);
	localparam int CMPW = (AW > IDX_W) ? AW : IDX_W;
	localparam logic [AW-1:0] FULL_AT = AW'(ENTRIES - 1);

	logic [KEY_W-1:0] key_store     [ENTRIES];
	logic [PAY_W-1:0] payload_store [ENTRIES];

	logic [1:0]       action_q;
	logic [IDX_W-1:0] idx_q;
	logic [KEY_W-1:0] nkey_q;
	logic [PAY_W-1:0] npay_q;
	logic [AW-1:0]    ptr_q;
	logic [AW-1:0]    count_q;
	logic [KEY_W-1:0] rkey_q;
	logic [PAY_W-1:0] rpay_q;

	logic [AW-1:0]    raddr;
	logic [AW-1:0]    count_next;
	logic             full;
	logic             oor;

	assign full = (count_q >= FULL_AT);
	assign oor  = (CMPW'(idx_q) >= CMPW'(count_q));

	always_comb begin
		sts.action   = action_q;
		sts.full     = full;
		sts.oor      = oor;
		sts.ptr_zero = (ptr_q == '0);
		sts.del_end  = ({1'b0, ptr_q} + (AW+1)'(1)) >= {1'b0, count_q};
		sts.key_less = (nkey_q < rkey_q);
	end

	always_comb begin
		case (cmd.rd_sel)
			RA_PREV: raddr = ptr_q - AW'(1);
			RA_NEXT: raddr = ptr_q + AW'(1);
			default: raddr = ptr_q;
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (action_q == ACT_INSERT && !full)
			count_next = count_q + AW'(1);
		else if (action_q == ACT_DELETE && !oor)
			count_next = count_q - AW'(1);
	end

	// Operands and walk pointer.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			idx_q    <= index;
			nkey_q   <= {year, month, day, hour, minute};
			npay_q   <= {birthday, repeat_days, tag};
			ptr_q    <= (action == ACT_INSERT) ? count_q : AW'(index);
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - AW'(1);
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + AW'(1);
		end
	end

	// Entry memories: one write at the pointer, one registered read.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			key_store[ptr_q]     <= cmd.wr_new ? nkey_q : rkey_q;
			payload_store[ptr_q] <= cmd.wr_new ? npay_q : rpay_q;
		end
		if (cmd.rd_en) begin
			rkey_q <= key_store[raddr];
			rpay_q <= payload_store[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_next;
		end
	end

	// Result registers, loaded once per transaction.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status          <= STS_OK;
			position        <= '0;
			placed_last     <= 1'b0;
			out_year        <= '0;
			out_month       <= '0;
			out_day         <= '0;
			out_hour        <= '0;
			out_minute      <= '0;
			kind            <= KIND_SINGLE;
			out_repeat_days <= '0;
			out_tag         <= '0;
			entry_count     <= IDX_W'(count_next);
			case (action_q)
				ACT_INSERT: begin
					if (full) begin
						status <= STS_FULL;
					end else begin
						position    <= IDX_W'(ptr_q);
						placed_last <= (ptr_q == count_q);
					end
				end
				ACT_DELETE: begin
					if (oor)
						status <= STS_OOR;
				end
				ACT_READ: begin
					if (oor) begin
						status <= STS_OOR;
					end else begin
						out_year        <= rkey_q[33:20];
						out_month       <= rkey_q[19:16];
						out_day         <= rkey_q[15:11];
						out_hour        <= rkey_q[10:6];
						out_minute      <= rkey_q[5:0];
						out_repeat_days <= rpay_q[30:16];
						out_tag         <= rpay_q[15:0];
						if (rpay_q[31])
							kind <= KIND_BIRTHDAY;
						else if (rpay_q[30:16] != '0)
							kind <= KIND_REPEATING;
						else
							kind <= KIND_SINGLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/sevt_ctrl.sv]
// ----------------------------------------------------------------------------
// sevt_ctrl
// Sequencer for insert, delete and read walks and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module sevt_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire sevt_pkg::sevt_sts_t  sts,
	output sevt_pkg::sevt_cmd_t       cmd
);
	import sevt_pkg::*;

`include "assert_macros.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_INS_STEP,
		S_INS_CMP,
		S_DEL_STEP,
		S_DEL_MOVE,
		S_RD_DATA,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.rd_sel = RA_PTR;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.action)
					ACT_INSERT: state_d = sts.full ? S_FINISH : S_INS_STEP;
					ACT_DELETE: state_d = sts.oor ? S_FINISH : S_DEL_STEP;
					ACT_READ: begin
						if (sts.oor) begin
							state_d = S_FINISH;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = S_RD_DATA;
						end
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_INS_STEP: begin
				if (sts.ptr_zero) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_new = 1'b1;
					state_d    = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_PREV;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				// shift the larger entry up, or drop the new one into the gap
				cmd.wr_en = 1'b1;
				if (sts.key_less) begin
					cmd.ptr_dec = 1'b1;
					state_d     = S_INS_STEP;
				end else begin
					cmd.wr_new = 1'b1;
					state_d    = S_FINISH;
				end
			end
			S_DEL_STEP: begin
				if (sts.del_end) begin
					state_d = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_NEXT;
					state_d    = S_DEL_MOVE;
				end
			end
			S_DEL_MOVE: begin
				cmd.wr_en   = 1'b1;
				cmd.ptr_inc = 1'b1;
				state_d     = S_DEL_STEP;
			end
			S_RD_DATA: state_d = S_FINISH;
			S_FINISH: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`ASSERT_CLK(a_commit_free, clk, arst_n, cmd.commit |-> (!out_valid_q || out_ready))
	`ASSERT_CLK(a_commit_shows, clk, arst_n, cmd.commit |=> out_valid_q)
	`ASSERT_CLK(a_accept_decode, clk, arst_n, (in_valid && in_ready) |=> state_q == S_DECODE)
	`ASSERT_NEVER(a_rw_idle, clk, arst_n, state_q == S_IDLE && (cmd.wr_en || cmd.rd_en))

endmodule

`default_nettype wire

[sv/sorted_event_table_core.sv]
// ----------------------------------------------------------------------------
// sorted_event_table_core
// Event table kept in ascending order of year, month, day, hour, minute.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one command transaction: insert,
// delete at index or read at index. Output channel (out_valid/out_ready)
// returns exactly one result transaction for each command.
// in_ready is high while the sequencer is idle; a result may still wait in
// the output register while the next command is taken.
// Time from accept to result valid grows with the entries that move:
//   insert moves the entries that sit after the new one, delete moves the
//   entries above the deleted position; read and refused commands move none.
// Each moved entry costs one read and one write of the entry memory.
// The sequencer returns to idle, taking commands again, as the result loads.
// Reset empties the table at once (count to zero); entry memory is not
// cleared. When the receiver stalls, a finished command waits in its last
// step until the output register frees up, and no further command is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_event_table_core #(
	parameter int ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [5:0]  index,
	input  wire logic [13:0] year,
	input  wire logic [3:0]  month,
	input  wire logic [4:0]  day,
	input  wire logic [4:0]  hour,
	input  wire logic [5:0]  minute,
	input  wire logic        birthday,
	input  wire logic [14:0] repeat_days,
	input  wire logic [15:0] tag,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [5:0]       position,
	output logic             placed_last,
	output logic [13:0]      out_year,
	output logic [3:0]       out_month,
	output logic [4:0]       out_day,
	output logic [4:0]       out_hour,
	output logic [5:0]       out_minute,
	output logic [1:0]       kind,
	output logic [14:0]      out_repeat_days,
	output logic [15:0]      out_tag,
	output logic [5:0]       entry_count
);
	import sevt_pkg::*;

	sevt_cmd_t cmd;
	sevt_sts_t sts;

	sevt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sevt_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.action          (action),
		.index           (index),
		.year            (year),
		.month           (month),
		.day             (day),
		.hour            (hour),
		.minute          (minute),
		.birthday        (birthday),
		.repeat_days     (repeat_days),
		.tag             (tag),
		.status          (status),
		.position        (position),
		.placed_last     (placed_last),
		.out_year        (out_year),
		.out_month       (out_month),
		.out_day         (out_day),
		.out_hour        (out_hour),
		.out_minute      (out_minute),
		.kind            (kind),
		.out_repeat_days (out_repeat_days),
		.out_tag         (out_tag),
		.entry_count     (entry_count)
	);

endmodule

`default_nettype wire
